// File: rtl/x86_memory_operand_encoder_defines.svh
// Assertion macros for the x86 memory operand encoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef X86_MEMORY_OPERAND_ENCODER_DEFINES_SVH
`define X86_MEMORY_OPERAND_ENCODER_DEFINES_SVH

// Implication checked on every rising clk edge, off while rst_n is low.
`define XMOE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked while reset is asserted.
`define XMOE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/xmoe_pkg.sv
// Shared types and constants for the x86 memory operand encoder.
// No dependencies.
`default_nettype none
package xmoe_pkg;

  // displacement length codes; values double as the ModRM mod field
  localparam logic [1:0] DL_NONE = 2'd0;
  localparam logic [1:0] DL_BYTE = 2'd1;
  localparam logic [1:0] DL_WORD = 2'd2;

  // register numbers with special meaning in ModRM/SIB
  localparam logic [2:0] REG_ESP = 3'd4;
  localparam logic [2:0] REG_EBP = 3'd5;
  localparam logic [2:0] RM_SIB  = 3'd4;
  localparam logic [2:0] RM_D32  = 3'd5;

  // descriptor queue between classifier and serializer
  localparam int QAW    = 1;
  localparam int QDEPTH = 1 << QAW;

  // classified operand, ready to serialize
  typedef struct packed {
    logic        err;
    logic [7:0]  modrm;
    logic        sib_en;
    logic [7:0]  sib;
    logic [1:0]  dlen;
    logic [31:0] disp;
  } desc_t;

  // queue status toward the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: rtl/x86_memory_operand_encoder.sv
// Top level of the 32-bit x86 memory operand (ModRM/SIB/disp) encoder.
// Depends on xmoe_pkg, xmoe_front, xmoe_queue, xmoe_back and the defines header.
`default_nettype none
`include "x86_memory_operand_encoder_defines.svh"

// Usage: an operand is a transaction on start/busy (taken at a clock edge
// with start high and busy low). Each operand is classified at once and
// its descriptor lands in a two-entry queue; the serializer then drives
// one byte per clock on out_code_byte with out_strobe high: ModRM, SIB if
// needed, then 0, 1 or 4 displacement bytes little-endian, out_last on the
// final byte. An operand that cannot be encoded gives one byte 0x00 with
// out_error and out_last set. The bytes of one operand always come in
// consecutive cycles and the receiver cannot stall them. After
// acceptance the descriptor is written into the queue, and its first byte
// is then registered in the output byte register. An operand encodes to
// 1 to 6 bytes, and the byte-per-cycle serializer sets the sustained
// rate; busy rises only while the queue holds two operands, the one being
// serialized counted until its last byte goes out, so a new operand can
// be taken every cycle until the queue fills.
module x86_memory_operand_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_reg_field,
  input  logic        in_has_base,
  input  logic [2:0]  in_base_reg,
  input  logic        in_has_index,
  input  logic [2:0]  in_index_reg,
  input  logic [3:0]  in_multiplier,
  input  logic [31:0] in_displacement,
  output logic        out_strobe,
  output logic [7:0]  out_code_byte,
  output logic        out_last,
  output logic        out_error
);
  import xmoe_pkg::*;

  desc_t   new_desc;   // classifier result for the operand on the inputs
  desc_t   head_desc;  // descriptor being serialized
  q_stat_t q_stat;
  logic    push, pop;

  // front end: combinational classification, written straight into the queue
  xmoe_front u_front (
    .in_reg_field    (in_reg_field),
    .in_has_base     (in_has_base),
    .in_base_reg     (in_base_reg),
    .in_has_index    (in_has_index),
    .in_index_reg    (in_index_reg),
    .in_multiplier   (in_multiplier),
    .in_displacement (in_displacement),
    .desc            (new_desc)
  );

  // a pop frees a slot only at the edge, so busy looks at the full flag alone
  assign busy = q_stat.full;
  assign push = start && !busy;

  xmoe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (new_desc),
    .pop       (pop),
    .head      (head_desc),
    .stat      (q_stat)
  );

  // back end: one byte per cycle, pops the descriptor on its last byte
  xmoe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head_desc),
    .stat          (q_stat),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_code_byte (out_code_byte),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  // error transaction is a single zero byte
  `XMOE_ASSERT(a_err_single, (out_strobe && out_error) |-> (out_last && out_code_byte == 8'h00), "error byte must be a lone zero byte")
  // bytes of one operand are never split by an idle cycle
  `XMOE_ASSERT(a_no_gap, (out_strobe && !out_last) |=> out_strobe, "gap inside an operand's byte stream")
  // with an empty queue, an accepted operand's first byte follows via the queue entry and the output register
  `XMOE_ASSERT(a_latency, (push && q_stat.empty) |-> ##2 out_strobe, "first byte late after accept into empty queue")

endmodule
`default_nettype wire

// File: rtl/xmoe_front.sv
// Operand classifier: normalizes base/index/scale, picks the encoding form.
// Depends on xmoe_pkg.
`default_nettype none
module xmoe_front (
  input  logic [2:0]      in_reg_field,
  input  logic            in_has_base,
  input  logic [2:0]      in_base_reg,
  input  logic            in_has_index,
  input  logic [2:0]      in_index_reg,
  input  logic [3:0]      in_multiplier,
  input  logic [31:0]     in_displacement,
  output xmoe_pkg::desc_t desc
);
  import xmoe_pkg::*;

  logic       b_en, i_en, bad;
  logic [2:0] b_id, i_id;
  logic [1:0] sc, dsz;

  always_comb begin
    b_en = in_has_base;
    b_id = in_base_reg;
    i_en = in_has_index;
    i_id = in_index_reg;
    sc   = 2'd0;
    bad  = 1'b0;
    if (in_has_index && in_index_reg == REG_ESP) begin
      // esp cannot be an index: it becomes the base, SIB index "none"
      bad  = (in_multiplier > 4'd1) || in_has_base;
      b_en = 1'b1;
      b_id = REG_ESP;
    end else if (!in_has_index) begin
      // lone base goes to the index slot; esp keeps its base role too
      i_en = in_has_base;
      i_id = in_base_reg;
      b_en = in_has_base && (in_base_reg == REG_ESP);
    end else begin
      unique case (in_multiplier) inside
        4'd0, 4'd1: sc = 2'd0;
        4'd2:       sc = 2'd1;
        4'd4:       sc = 2'd2;
        4'd8:       sc = 2'd3;
        4'd3, 4'd5, 4'd9: begin
          // reg*k+reg: index doubles as base
          bad  = in_has_base;
          b_en = 1'b1;
          b_id = in_index_reg;
          sc   = (in_multiplier == 4'd3) ? 2'd1 :
                 (in_multiplier == 4'd5) ? 2'd2 : 2'd3;
        end
        default:    bad = 1'b1;
      endcase
    end
  end

  always_comb begin
    if (in_displacement == 32'd0) begin
      dsz = DL_NONE;
    end else if (&in_displacement[31:7] || ~|in_displacement[31:7]) begin
      dsz = DL_BYTE;
    end else begin
      dsz = DL_WORD;
    end

    desc        = '0;
    desc.disp   = in_displacement;
    if (bad) begin
      desc.err  = 1'b1;
      desc.dlen = DL_NONE;
    end else if (!i_en) begin
      // absolute disp32
      desc.modrm = {2'b00, in_reg_field, RM_D32};
      desc.dlen  = DL_WORD;
    end else if (sc == 2'd0 && !b_en) begin
      if (i_id == REG_EBP && dsz == DL_NONE) dsz = DL_BYTE;
      desc.modrm = {dsz, in_reg_field, i_id};
      desc.dlen  = dsz;
    end else if (!b_en) begin
      // scaled index without base: SIB base field means disp32
      desc.modrm  = {2'b00, in_reg_field, RM_SIB};
      desc.sib_en = 1'b1;
      desc.sib    = {sc, i_id, RM_D32};
      desc.dlen   = DL_WORD;
    end else begin
      if (b_id == REG_EBP && dsz == DL_NONE) dsz = DL_BYTE;
      desc.modrm  = {dsz, in_reg_field, RM_SIB};
      desc.sib_en = 1'b1;
      desc.sib    = {sc, i_id, b_id};
      desc.dlen   = dsz;
    end
  end

endmodule
`default_nettype wire

// File: rtl/xmoe_queue.sv
// Small descriptor FIFO between classifier and byte serializer.
// Depends on xmoe_pkg.
`default_nettype none
module xmoe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xmoe_pkg::desc_t   push_data,
  input  logic              pop,
  output xmoe_pkg::desc_t   head,
  output xmoe_pkg::q_stat_t stat
);
  import xmoe_pkg::*;

  desc_t            ent_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule
`default_nettype wire

// File: rtl/xmoe_back.sv
// Byte serializer: walks the head descriptor one byte per cycle.
// Depends on xmoe_pkg.
`default_nettype none
module xmoe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xmoe_pkg::desc_t   head,
  input  xmoe_pkg::q_stat_t stat,
  output logic              pop,
  output logic              out_strobe,
  output logic [7:0]        out_code_byte,
  output logic              out_last,
  output logic              out_error
);
  import xmoe_pkg::*;

  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] last_idx, d_idx;
  logic       emit, is_last;
  logic [7:0] byte_val;
  logic       strobe_r;
  logic [7:0] byte_r;
  logic       last_r, err_r;

  always_comb begin
    last_idx = {2'b00, head.sib_en};
    case (head.dlen)
      DL_BYTE: last_idx = last_idx + 3'd1;
      DL_WORD: last_idx = last_idx + 3'd4;
      default: last_idx = last_idx;
    endcase

    emit    = !stat.empty;
    is_last = (cnt_r == last_idx);
    pop     = emit && is_last;
    cnt_nxt = emit ? (is_last ? 3'd0 : cnt_r + 3'd1) : cnt_r;

    // position within the displacement, little-endian
    d_idx = cnt_r - 3'd1 - {2'b00, head.sib_en};
    if (cnt_r == 3'd0) begin
      byte_val = head.modrm;
    end else if (head.sib_en && cnt_r == 3'd1) begin
      byte_val = head.sib;
    end else begin
      case (d_idx[1:0])
        2'd0:    byte_val = head.disp[7:0];
        2'd1:    byte_val = head.disp[15:8];
        2'd2:    byte_val = head.disp[23:16];
        default: byte_val = head.disp[31:24];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_val;
    last_r <= is_last;
    err_r  <= head.err;
  end

  assign out_strobe    = strobe_r;
  assign out_code_byte = byte_r;
  assign out_last      = last_r;
  assign out_error     = err_r;

endmodule
`default_nettype wire
